FILE: hdl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the parser RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define SDP_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define SDP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hdl/sdp_pkg.sv
// ------------------------------------------------------------------------
// sdp_pkg
// Types and character constants for the strict decimal parser.
// ------------------------------------------------------------------------
package sdp_pkg;

    // Parse phase
    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    // Running parse state carried between characters
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [31:0] magnitude;
    } parse_state_t;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam parse_state_t STATE_INIT = '{phase: PH_BLANK, negative: 1'b0,
                                            magnitude: 32'd0};

endpackage

FILE: hdl/sdp_step.sv
// ------------------------------------------------------------------------
// sdp_step
// One-character update of the parse state plus the result formed at NUL.
// ------------------------------------------------------------------------
module sdp_step (
    input  sdp_pkg::parse_state_t state_cur,
    input  logic [7:0]            char_code,
    output sdp_pkg::parse_state_t state_next,
    output logic signed [31:0]    res_value,
    output logic                  res_error
);

    logic        is_nul;
    logic        is_digit;
    logic        is_blank;
    logic        is_sign;
    logic [7:0]  digit_raw;
    logic [3:0]  digit;
    logic [35:0] mag_wide;
    logic [35:0] acc_next;
    logic [35:0] limit_wide;
    logic        overflow;

    // Character classes
    assign is_nul    = (char_code == sdp_pkg::CHAR_NUL);
    assign is_digit  = (char_code >= sdp_pkg::CHAR_ZERO) && (char_code <= sdp_pkg::CHAR_NINE);
    assign is_blank  = (char_code == sdp_pkg::CHAR_SPACE) ||
                       ((char_code >= sdp_pkg::CHAR_TAB) && (char_code <= sdp_pkg::CHAR_CR));
    assign is_sign   = (char_code == sdp_pkg::CHAR_PLUS) || (char_code == sdp_pkg::CHAR_MINUS);
    assign digit_raw = char_code - sdp_pkg::CHAR_ZERO;
    assign digit     = digit_raw[3:0];

    // magnitude * 10 + digit as shift-add, compared against the sign's limit
    assign mag_wide   = {4'd0, state_cur.magnitude};
    assign acc_next   = (mag_wide << 3) + (mag_wide << 1) + {32'd0, digit};
    assign limit_wide = {4'd0, state_cur.negative ? sdp_pkg::NEG_LIMIT : sdp_pkg::POS_LIMIT};
    assign overflow   = (acc_next > limit_wide);

    // Result at the terminator
    always_comb begin
        if (state_cur.phase == sdp_pkg::PH_DIGITS) begin
            res_value = state_cur.negative ? (32'sd0 - $signed(state_cur.magnitude))
                                           : $signed(state_cur.magnitude);
            res_error = 1'b0;
        end else begin
            res_value = 32'sd0;
            res_error = 1'b1;
        end
    end

    // Next parse state
    always_comb begin
        state_next = state_cur;
        if (is_nul) begin
            state_next = sdp_pkg::STATE_INIT;
        end else begin
            unique case (state_cur.phase)
                sdp_pkg::PH_BLANK: begin
                    if (is_blank) begin
                        state_next = state_cur;
                    end else if (is_sign) begin
                        state_next.negative = (char_code == sdp_pkg::CHAR_MINUS);
                        state_next.phase    = sdp_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        state_next.magnitude = {28'd0, digit};
                        state_next.phase     = sdp_pkg::PH_DIGITS;
                    end else begin
                        state_next.phase = sdp_pkg::PH_ERROR;
                    end
                end
                sdp_pkg::PH_SIGN: begin
                    if (is_digit) begin
                        state_next.magnitude = {28'd0, digit};
                        state_next.phase     = sdp_pkg::PH_DIGITS;
                    end else begin
                        state_next.phase = sdp_pkg::PH_ERROR;
                    end
                end
                sdp_pkg::PH_DIGITS: begin
                    if (is_digit && !overflow) begin
                        state_next.magnitude = acc_next[31:0];
                    end else begin
                        state_next.phase = sdp_pkg::PH_ERROR;
                    end
                end
                default: begin
                    state_next = state_cur;
                end
            endcase
        end
    end

endmodule

FILE: hdl/strict_decimal_to_int32_parser_unit.sv
// ------------------------------------------------------------------------
// strict_decimal_to_int32_parser_unit
// Streaming strict decimal string to signed 32-bit integer parser.
// ------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_char_code) takes one byte per request.
//   A NUL byte ends the string; only NUL produces a result request on the
//   output channel (m_valid/m_ready/m_value/m_error).
//   Leading blanks, one optional sign and at least one digit are required;
//   anything else, or a value outside the int32 range, gives m_error = 1
//   with m_value = 0. Both int32 limits are accepted.
// Timing:
//   A byte lands in the input register and is folded into the parse state
//   from there by one shift-add-compare step; a NUL loads the result
//   register on the same edge that folds it, which raises m_valid. Throughput
//   is one byte per cycle while no NUL waits on a full result register,
//   set by the times-ten update of the magnitude register.
// Reset:
//   aresetn (synchronous, active low) empties both registers and returns the
//   parse state to leading-blank scanning.
// Stall:
//   Non-NUL bytes keep flowing while a result waits; a NUL waits in the
//   input register, with s_ready low, until the result register frees.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module strict_decimal_to_int32_parser_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic               m_error
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    sdp_pkg::parse_state_t state_reg;
    sdp_pkg::parse_state_t state_next;
    logic                  out_valid_reg;
    logic signed [31:0]    value_reg;
    logic                  error_reg;
    logic signed [31:0]    res_value;
    logic                  res_error;
    logic                  char_is_nul;
    logic                  advance;

    // Character step
    sdp_step u_step (
        .state_cur  (state_reg),
        .char_code  (char_reg),
        .state_next (state_next),
        .res_value  (res_value),
        .res_error  (res_error)
    );

    // Held byte moves on unless it is a NUL facing a full result register that m_ready does not free
    assign char_is_nul = (char_reg == sdp_pkg::CHAR_NUL);
    assign advance     = in_valid_reg && (!char_is_nul || !out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdp_pkg::STATE_INIT;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && char_is_nul) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && char_is_nul) begin
            value_reg <= res_value;
            error_reg <= res_error;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = value_reg;
    assign m_error = error_reg;

    // Checks
    `SDP_ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> !m_valid && (state_reg.phase == sdp_pkg::PH_BLANK),
        "reset left a result or parse state behind")
    `SDP_ASSERT(a_error_zero, aclk, aresetn,
        m_valid && m_error |-> m_value == 32'sd0,
        "error result with nonzero value")
    `SDP_ASSERT(a_nul_restarts, aclk, aresetn,
        advance && char_is_nul |=> state_reg == sdp_pkg::STATE_INIT,
        "terminator did not restart the parse")
    `SDP_ASSERT(a_no_digits_zero, aclk, aresetn,
        (state_reg.phase == sdp_pkg::PH_BLANK || state_reg.phase == sdp_pkg::PH_SIGN)
            |-> state_reg.magnitude == 32'd0,
        "magnitude set before any digit")
    `SDP_ASSERT(a_pos_bound, aclk, aresetn,
        state_reg.phase == sdp_pkg::PH_DIGITS && !state_reg.negative
            |-> state_reg.magnitude <= sdp_pkg::POS_LIMIT,
        "positive magnitude past int32 max")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb
// Self-checking bench for the strict decimal to int32 parser: streams
// strings byte by byte, mirrors the parse in a local model and compares
// every result request against the expected value and error flag.
// ------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 1100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 8;

    typedef struct packed {
        logic signed [31:0] value;
        logic               error;
    } int_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_char_code;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value;
    logic               m_error;

    strict_decimal_to_int32_parser_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_error     (m_error)
    );

    // Local copy of the parse state
    sdp_pkg::phase_t ps_phase = sdp_pkg::PH_BLANK;
    bit              ps_neg   = 1'b0;
    logic [31:0]     ps_mag   = 32'd0;

    int_result_t parsed_results[$];
    logic [7:0]  str_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          idle_cycles    = 0;
    bit          drain_hold     = 1'b0;
    bit          no_idle        = 1'b0;

    // Typed expectation for the request currently offered
    bit          cur_typed = 1'b0;
    int_result_t cur_typed_res = '0;

    // Directed strings (a NUL is appended to each); typed results where obvious
    string       dir_text  [DIR_ROWS] = '{"", " +", "- 1", "\t2147483647", "-2147483648",
                                          "9\377", "\015-0045", "2147483648"};
    bit          dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [31:0] dir_value [DIR_ROWS] = '{32'd0, 32'd0, 32'd0, sdp_pkg::POS_LIMIT,
                                          sdp_pkg::NEG_LIMIT, 32'd0, 32'd0, 32'd0};
    bit          dir_error [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Fold one byte into the local parse state; a NUL yields a result
    task automatic parse_char(input logic [7:0] c, output bit fired, output int_result_t res);
        logic [63:0] grown;
        logic [63:0] bound;
        bit          is_dig;
        bit          is_blank;
        fired    = 1'b0;
        res      = '0;
        is_dig   = (c >= sdp_pkg::CHAR_ZERO) && (c <= sdp_pkg::CHAR_NINE);
        is_blank = (c == sdp_pkg::CHAR_SPACE) ||
                   ((c >= sdp_pkg::CHAR_TAB) && (c <= sdp_pkg::CHAR_CR));
        if (c == sdp_pkg::CHAR_NUL) begin
            fired = 1'b1;
            if (ps_phase == sdp_pkg::PH_DIGITS) begin
                res.value = ps_neg ? -ps_mag : ps_mag;
                res.error = 1'b0;
            end else begin
                res.value = 32'd0;
                res.error = 1'b1;
            end
            ps_phase = sdp_pkg::PH_BLANK;
            ps_neg   = 1'b0;
            ps_mag   = 32'd0;
        end else begin
            case (ps_phase)
                sdp_pkg::PH_BLANK: begin
                    if (is_blank) begin
                        ps_phase = sdp_pkg::PH_BLANK;
                    end else if (c == sdp_pkg::CHAR_MINUS || c == sdp_pkg::CHAR_PLUS) begin
                        ps_neg   = (c == sdp_pkg::CHAR_MINUS);
                        ps_phase = sdp_pkg::PH_SIGN;
                    end else if (is_dig) begin
                        ps_mag   = {24'd0, c - sdp_pkg::CHAR_ZERO};
                        ps_phase = sdp_pkg::PH_DIGITS;
                    end else begin
                        ps_phase = sdp_pkg::PH_ERROR;
                    end
                end
                sdp_pkg::PH_SIGN: begin
                    if (is_dig) begin
                        ps_mag   = {24'd0, c - sdp_pkg::CHAR_ZERO};
                        ps_phase = sdp_pkg::PH_DIGITS;
                    end else begin
                        ps_phase = sdp_pkg::PH_ERROR;
                    end
                end
                sdp_pkg::PH_DIGITS: begin
                    if (is_dig) begin
                        grown = {32'd0, ps_mag} * 64'd10 + {56'd0, c - sdp_pkg::CHAR_ZERO};
                        bound = ps_neg ? {32'd0, sdp_pkg::NEG_LIMIT}
                                       : {32'd0, sdp_pkg::POS_LIMIT};
                        if (grown > bound) ps_phase = sdp_pkg::PH_ERROR;
                        else ps_mag = grown[31:0];
                    end else begin
                        ps_phase = sdp_pkg::PH_ERROR;
                    end
                end
                default: ps_phase = sdp_pkg::PH_ERROR;
            endcase
        end
    endtask

    // Offer one byte after a random gap and wait for it to be taken
    task automatic send_char(input logic [7:0] c, input bit use_typed,
                             input int_result_t typed_res);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) gap = 0;
        else if (r < 94) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 30);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_char_code   <= c;
        cur_typed     = use_typed;
        cur_typed_res = typed_res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the built string followed by its NUL
    task automatic send_string();
        foreach (str_bytes[i]) send_char(str_bytes[i], 1'b0, '0);
        send_char(sdp_pkg::CHAR_NUL, 1'b0, '0);
    endtask

    task automatic push_blanks(input int n);
        int b;
        repeat (n) begin
            b = $urandom_range(sdp_pkg::CHAR_TAB - 1, sdp_pkg::CHAR_CR);
            str_bytes.push_back((b == sdp_pkg::CHAR_TAB - 1) ? sdp_pkg::CHAR_SPACE : b[7:0]);
        end
    endtask

    task automatic push_sign();
        int r;
        r = $urandom_range(0, 2);
        if (r == 1) str_bytes.push_back(sdp_pkg::CHAR_PLUS);
        else if (r == 2) str_bytes.push_back(sdp_pkg::CHAR_MINUS);
    endtask

    task automatic push_number(input logic [31:0] m);
        logic [7:0] digits[$];
        logic [31:0] rest;
        rest = m;
        do begin
            digits.push_front(sdp_pkg::CHAR_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        foreach (digits[i]) str_bytes.push_back(digits[i]);
    endtask

    // Mostly well-formed strings with random content, plus broken ones and noise
    task automatic build_random_string();
        int kind;
        int r;
        int n;
        str_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            push_blanks($urandom_range(0, 2));
            push_sign();
            if ($urandom_range(0, 1)) push_number($urandom());
            else push_number($urandom_range(0, 99999));
        end else if (kind < 50) begin
            // straddle both int32 limits
            push_blanks($urandom_range(0, 1));
            push_sign();
            push_number(32'h7FFF_FFF8 + $urandom_range(0, 15));
        end else if (kind < 65) begin
            push_sign();
            n = $urandom_range(1, 12);
            repeat (n) str_bytes.push_back(sdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end else if (kind < 80) begin
            push_blanks($urandom_range(0, 1));
            push_sign();
            push_number($urandom_range(0, 9999));
            if ($urandom_range(0, 1)) begin
                str_bytes.insert($urandom_range(0, str_bytes.size()),
                                 8'($urandom_range(1, 255)));
            end else begin
                push_blanks($urandom_range(1, 2));
            end
        end else if (kind < 90) begin
            n = $urandom_range(0, 6);
            repeat (n) str_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            r = $urandom_range(0, 2);
            push_blanks($urandom_range(0, 3));
            if (r >= 1) push_sign();
            if (r == 2) begin
                push_blanks(1);
                str_bytes.push_back(sdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    // Result checking, then prediction of the request taken at this edge
    always @(posedge aclk) begin
        int_result_t exp_res;
        int_result_t got_res;
        bit          fired;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (parsed_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: value %0d error %0b", m_value, m_error);
                end else begin
                    exp_res = parsed_results.pop_front();
                    if (m_value !== exp_res.value || m_error !== exp_res.error) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected value %0d error %0b, got value %0d error %0b",
                                     exp_res.value, exp_res.error, m_value, m_error);
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_char(s_char_code, fired, got_res);
                if (fired) parsed_results.push_back(cur_typed ? cur_typed_res : got_res);
            end
            // Watchdog: cycles with no request accepted on either side
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", parsed_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (drain_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                drain_hold = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 20) stall_left = $urandom_range(1, 3);
                else if (r < 23) stall_left = $urandom_range(10, 40);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        bit held;
        bit quiet_done;
        held        = 1'b0;
        quiet_done  = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = 8'd0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int row = 0; row < DIR_ROWS; row++) begin
            for (int k = 0; k < dir_text[row].len(); k++)
                send_char(dir_text[row][k], 1'b0, '0);
            send_char(sdp_pkg::CHAR_NUL, dir_typed[row],
                      int_result_t'{value: dir_value[row], error: dir_error[row]});
        end

        // Random strings
        while (bytes_sent < RANDOM_ITEMS) begin
            if (!held && bytes_sent > 400) begin
                // receiver holds off while short strings keep coming
                held       = 1'b1;
                drain_hold = 1'b1;
                no_idle    = 1'b1;
                repeat (24) begin
                    str_bytes.delete();
                    str_bytes.push_back(sdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                    send_string();
                end
                no_idle = 1'b0;
            end else if (!quiet_done && bytes_sent > 800) begin
                // back-to-back stretch with no idling on either side
                quiet_done = 1'b1;
                no_idle    = 1'b1;
                repeat (20) begin
                    build_random_string();
                    send_string();
                end
                no_idle = 1'b0;
            end else begin
                build_random_string();
                send_string();
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (parsed_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && parsed_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
